/* design/cfh_pkg.sv */
// Shared types and constants of the CAN feedback identifier hash table.
// No dependencies; the front end, queue, back end, top level and testbench import it.
package cfh_pkg;

  localparam int unsigned MOTORS        = 8;
  localparam int unsigned SLOTS_DEFAULT = 16;

  localparam int unsigned BUS_W       = 8;
  localparam int unsigned ID_W        = 11;
  localparam int unsigned MOTOR_W     = 3;
  localparam int unsigned MOTOR_OUT_W = 4;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned BUS_SHIFT   = 5;
  // bus << BUS_SHIFT spans 13 bits and covers the 11-bit identifier
  localparam int unsigned MIX_W       = BUS_W + BUS_SHIFT;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic [MOTOR_OUT_W-1:0] MOTOR_NONE = MOTOR_OUT_W'(MOTORS);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_CLEAR,
    JOB_REJECT,
    JOB_INSERT,
    JOB_LOOKUP
  } job_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_SAME     = 3'd1,
    ST_CONFLICT = 3'd2,
    ST_FULL     = 3'd3,
    ST_REJECTED = 3'd4,
    ST_HIT      = 3'd5,
    ST_MISS     = 3'd6,
    ST_CLEARED  = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic {
    B_IDLE,
    B_PROBE
  } back_state_e;

  typedef struct packed {
    job_e                 job;
    logic [BUS_W-1:0]     bus;
    logic [ID_W-1:0]      id;
    logic [MOTOR_W-1:0]   motor;
  } item_t;

  typedef struct packed {
    logic [BUS_W-1:0]     bus;
    logic [ID_W-1:0]      id;
    logic [MOTOR_W-1:0]   motor;
  } slot_t;

endpackage

/* design/cfh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cfh_front.sv */
// Front end: accepts request items, classifies them and works out the home
// slot by a reciprocal multiply and a remainder step. Depends on cfh_pkg.
module cfh_front import cfh_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               command_i,
  input  logic [BUS_W-1:0]         bus_i,
  input  logic [ID_W-1:0]          feedback_id_i,
  input  logic [MOTOR_W-1:0]       motor_id_i,
  output logic                     push_o,
  output item_t                    item_o,
  output logic [$clog2(SLOTS)-1:0] home_o,
  input  logic                     q_full_i
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  // floor(2^MIX_W / SLOTS): (mix * RECIP) >> MIX_W is the quotient or one less
  localparam logic [MIX_W-1:0] RECIP   = MIX_W'((1 << MIX_W) / SLOTS);
  localparam logic [MIX_W-1:0] SLOTS_M = MIX_W'(SLOTS);

  front_state_e             state_q, state_d;
  item_t                    item_q, item_d;
  logic [MIX_W-1:0]         mix_q, mix_d;
  logic [MIX_W-1:0]         quo_q, quo_d;
  logic [SLOT_W-1:0]        home_q, home_d;
  logic [2*MIX_W-1:0]       product;
  logic [MIX_W-1:0]         rem_raw;
  logic                     accept;
  logic                     bad_insert;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign bad_insert = (bus_i == '0) ||
                      ((MOTOR_W + 1)'(motor_id_i) >= (MOTOR_W + 1)'(MOTORS));

  // quotient estimate, then remainder below 2*SLOTS, one subtract brings it home
  assign product = (2 * MIX_W)'(mix_q) * (2 * MIX_W)'(RECIP);
  assign rem_raw = mix_q - quo_q * SLOTS_M;

  always_comb begin
    state_d = state_q;
    item_d  = item_q;
    mix_d   = mix_q;
    quo_d   = quo_q;
    home_d  = home_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          item_d.bus   = bus_i;
          item_d.id    = feedback_id_i;
          item_d.motor = motor_id_i;
          mix_d        = MIX_W'(feedback_id_i) ^ (MIX_W'(bus_i) << BUS_SHIFT);
          case (command_i)
            CMD_CLEAR: begin
              item_d.job = JOB_CLEAR;
              state_d    = F_PUSH;
            end
            CMD_INSERT: begin
              if (bad_insert) begin
                item_d.job = JOB_REJECT;
                state_d    = F_PUSH;
              end else begin
                item_d.job = JOB_INSERT;
                state_d    = F_HASH;
              end
            end
            CMD_LOOKUP: begin
              item_d.job = JOB_LOOKUP;
              state_d    = F_HASH;
            end
            default: ;  // unused code: item dropped
          endcase
        end
      end
      F_HASH: begin
        quo_d   = product[2*MIX_W-1:MIX_W];
        state_d = F_MOD;
      end
      F_MOD: begin
        home_d  = (rem_raw >= SLOTS_M) ? SLOT_W'(rem_raw - SLOTS_M) : SLOT_W'(rem_raw);
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    mix_q  <= mix_d;
    quo_q  <= quo_d;
    home_q <= home_d;
  end

  assign item_o = item_q;
  assign home_o = home_q;

endmodule

/* design/cfh_queue.sv */
// Two-entry queue of classified items between front and back end.
// Depends on cfh_pkg.
module cfh_queue import cfh_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  item_t                    item_i,
  input  logic [$clog2(SLOTS)-1:0] home_i,
  output logic                     full_o,
  input  logic                     pop_i,
  output logic                     valid_o,
  output item_t                    item_o,
  output logic [$clog2(SLOTS)-1:0] home_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);

  item_t             item_q [QDEPTH];
  logic [SLOT_W-1:0] home_q [QDEPTH];
  logic [QAW-1:0]    wr_q, rd_q;
  logic [QAW:0]      count_q;

  assign full_o  = (count_q == (QAW + 1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = item_q[rd_q];
  assign home_o  = home_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q[wr_q] <= item_i;
      home_q[wr_q] <= home_i;
    end
  end

endmodule

/* design/cfh_back.sv */
// Back end: clear, reject, and linear probing over the slot RAM, plus the
// diagnostics and the result register. Depends on cfh_pkg and cfh_ram.
module cfh_back import cfh_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  item_t                    item_i,
  input  logic [$clog2(SLOTS)-1:0] home_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               status_o,
  output logic [MOTOR_OUT_W-1:0]   found_motor_o,
  output logic [CNT_W-1:0]         conflict_total_o,
  output logic [CNT_W-1:0]         full_total_o,
  output logic [BUS_W-1:0]         conflict_bus_o,
  output logic [ID_W-1:0]          conflict_id_o,
  output logic [MOTOR_OUT_W-1:0]   conflict_kept_o,
  output logic [MOTOR_OUT_W-1:0]   conflict_dropped_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  back_state_e              state_q, state_d;
  job_e                     job_q, job_d;
  slot_t                    key_q, key_d;
  logic [SLOT_W-1:0]        probe_q, probe_d, probe_next;
  logic [SLOT_W-1:0]        count_q, count_d;
  logic [SLOTS-1:0]         used_q, used_d;
  logic [CNT_W-1:0]         conf_cnt_q, conf_cnt_d;
  logic [CNT_W-1:0]         full_cnt_q, full_cnt_d;
  logic [BUS_W-1:0]         conf_bus_q, conf_bus_d;
  logic [ID_W-1:0]          conf_id_q, conf_id_d;
  logic [MOTOR_OUT_W-1:0]   kept_q, kept_d;
  logic [MOTOR_OUT_W-1:0]   dropped_q, dropped_d;
  status_e                  status_q, status_d;
  logic [MOTOR_OUT_W-1:0]   found_q, found_d;
  logic                     out_valid_q, out_valid_d;

  logic                     ram_we;
  logic [SLOT_W-1:0]        ram_raddr;
  slot_t                    ram_rdata;
  logic                     slot_used;
  logic                     key_hit;
  logic                     last_probe;

  cfh_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (probe_q),
    .wdata_i (key_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign probe_next = (probe_q == LAST_SLOT) ? '0 : probe_q + 1'b1;
  // read one slot ahead so one slot is compared per cycle
  assign ram_raddr  = (state_q == B_IDLE) ? home_i : probe_next;
  assign slot_used  = used_q[probe_q];
  assign key_hit    = slot_used && (ram_rdata.bus == key_q.bus) &&
                      (ram_rdata.id == key_q.id);
  assign last_probe = (count_q == LAST_SLOT);

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    key_d       = key_q;
    probe_d     = probe_q;
    count_d     = count_q;
    used_d      = used_q;
    conf_cnt_d  = conf_cnt_q;
    full_cnt_d  = full_cnt_q;
    conf_bus_d  = conf_bus_q;
    conf_id_d   = conf_id_q;
    kept_d      = kept_q;
    dropped_d   = dropped_q;
    status_d    = status_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          pop_o   = 1'b1;
          found_d = MOTOR_NONE;
          job_d   = item_i.job;
          key_d   = '{bus: item_i.bus, id: item_i.id, motor: item_i.motor};
          probe_d = home_i;
          count_d = '0;
          case (item_i.job)
            JOB_CLEAR: begin
              used_d      = '0;
              conf_cnt_d  = '0;
              full_cnt_d  = '0;
              conf_bus_d  = '0;
              conf_id_d   = '0;
              kept_d      = MOTOR_NONE;
              dropped_d   = MOTOR_NONE;
              status_d    = ST_CLEARED;
              out_valid_d = 1'b1;
            end
            JOB_REJECT: begin
              status_d    = ST_REJECTED;
              out_valid_d = 1'b1;
            end
            default: state_d = B_PROBE;
          endcase
        end
      end
      B_PROBE: begin
        out_valid_d = 1'b1;
        state_d     = B_IDLE;
        if (job_q == JOB_INSERT) begin
          if (!slot_used) begin
            ram_we          = 1'b1;
            used_d[probe_q] = 1'b1;
            status_d        = ST_INSERTED;
          end else if (key_hit) begin
            if (ram_rdata.motor == key_q.motor) begin
              status_d = ST_SAME;
            end else begin
              status_d   = ST_CONFLICT;
              conf_cnt_d = conf_cnt_q + 1'b1;
              conf_bus_d = key_q.bus;
              conf_id_d  = key_q.id;
              kept_d     = MOTOR_OUT_W'(ram_rdata.motor);
              dropped_d  = MOTOR_OUT_W'(key_q.motor);
            end
          end else if (last_probe) begin
            status_d   = ST_FULL;
            full_cnt_d = full_cnt_q + 1'b1;
          end else begin
            out_valid_d = 1'b0;
            state_d     = B_PROBE;
          end
        end else begin
          if (!slot_used) begin
            status_d = ST_MISS;
          end else if (key_hit) begin
            status_d = ST_HIT;
            found_d  = MOTOR_OUT_W'(ram_rdata.motor);
          end else if (last_probe) begin
            status_d = ST_MISS;
          end else begin
            out_valid_d = 1'b0;
            state_d     = B_PROBE;
          end
        end
        if (state_d == B_PROBE) begin
          probe_d = probe_next;
          count_d = count_q + 1'b1;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      used_q      <= '0;
      conf_cnt_q  <= '0;
      full_cnt_q  <= '0;
      conf_bus_q  <= '0;
      conf_id_q   <= '0;
      kept_q      <= MOTOR_NONE;
      dropped_q   <= MOTOR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      conf_cnt_q  <= conf_cnt_d;
      full_cnt_q  <= full_cnt_d;
      conf_bus_q  <= conf_bus_d;
      conf_id_q   <= conf_id_d;
      kept_q      <= kept_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    key_q    <= key_d;
    probe_q  <= probe_d;
    count_q  <= count_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  // diagnostics only change when a new result is loaded, so they stay
  // steady while the result waits
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign found_motor_o      = found_q;
  assign conflict_total_o   = conf_cnt_q;
  assign full_total_o       = full_cnt_q;
  assign conflict_bus_o     = conf_bus_q;
  assign conflict_id_o      = conf_id_q;
  assign conflict_kept_o    = kept_q;
  assign conflict_dropped_o = dropped_q;

endmodule

/* design/can_feedback_id_hash_table.sv */
// CAN feedback identifier hash table: top level joining front end, queue
// and back end. Depends on cfh_pkg, cfh_front, cfh_queue, cfh_back.
//
// Use: each request item carries a command (clear, insert, look up), a bus,
// an 11-bit feedback identifier and a motor number. Items enter on
// in_valid_i / in_stall_o and are taken at an edge where valid is high and
// stall is low. The unused command code is taken and dropped, no result.
// Every other item gives exactly one result on out_valid_o / out_stall_i:
// status, the motor found on a lookup hit (8 = none) and the diagnostics
// as they stand after that command.
// Clear and rejected inserts go from the front end straight to its push state;
// insert and lookup first pass the quotient multiply and the remainder
// states. The front end takes no new item until it has pushed the last one;
// the back end probes one slot per cycle out of the slot RAM, from the home
// slot on, at most SLOTS slots. A two-entry queue lets the next item hash
// while the current one probes; the back end takes a new item only once its
// last result has been taken by the output side.
// Reset empties the table and clears the diagnostics at once; no sweep.
// A stalled result holds all outputs; the back end waits, the queue
// fills, and the front end then stalls the input.
module can_feedback_id_hash_table import cfh_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  logic [BUS_W-1:0]       bus_i,
  input  logic [ID_W-1:0]        feedback_id_i,
  input  logic [MOTOR_W-1:0]     motor_id_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic [MOTOR_OUT_W-1:0] found_motor_o,
  output logic [CNT_W-1:0]       conflict_total_o,
  output logic [CNT_W-1:0]       full_total_o,
  output logic [BUS_W-1:0]       conflict_bus_o,
  output logic [ID_W-1:0]        conflict_id_o,
  output logic [MOTOR_OUT_W-1:0] conflict_kept_o,
  output logic [MOTOR_OUT_W-1:0] conflict_dropped_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);

  logic              push;
  item_t             f_item;
  logic [SLOT_W-1:0] f_home;
  logic              q_full;
  logic              pop;
  logic              q_valid;
  item_t             q_item;
  logic [SLOT_W-1:0] q_home;

  // front: accept, classify, hash
  cfh_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .bus_i         (bus_i),
    .feedback_id_i (feedback_id_i),
    .motor_id_i    (motor_id_i),
    .push_o        (push),
    .item_o        (f_item),
    .home_o        (f_home),
    .q_full_i      (q_full)
  );

  // short queue decoupling hashing from probing
  cfh_queue #(
    .SLOTS (SLOTS)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .home_i  (f_home),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item),
    .home_o  (q_home)
  );

  // back: table, diagnostics, result register
  cfh_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .item_i             (q_item),
    .home_i             (q_home),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .found_motor_o      (found_motor_o),
    .conflict_total_o   (conflict_total_o),
    .full_total_o       (full_total_o),
    .conflict_bus_o     (conflict_bus_o),
    .conflict_id_o      (conflict_id_o),
    .conflict_kept_o    (conflict_kept_o),
    .conflict_dropped_o (conflict_dropped_o)
  );

`ifndef SYNTHESIS
  // a motor is reported only on a lookup hit
  a_found_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_HIT) |-> found_motor_o == MOTOR_NONE)
    else $error("found motor outside a lookup hit");

  a_hit_motor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_HIT) |-> found_motor_o < MOTOR_NONE)
    else $error("lookup hit without a valid motor");

  // a clear result shows freshly reset diagnostics
  a_clear_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CLEARED) |->
      (conflict_total_o == '0) && (full_total_o == '0) &&
      (conflict_kept_o == MOTOR_NONE) && (conflict_dropped_o == MOTOR_NONE))
    else $error("diagnostics not reset by clear");

  // the diagnostic counters must not move while a result waits
  a_diag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(conflict_total_o) && $stable(full_total_o))
    else $error("diagnostics changed under a stalled result");
`endif

endmodule

/* sim/tb_can_feedback_id_hash_table.sv */
`timescale 1ns / 1ps
// Self-checking testbench for can_feedback_id_hash_table: directed table, then random keyed traffic.
// Depends on cfh_pkg and the block's RTL; carries its own table predictor and result checker.
module tb_can_feedback_id_hash_table;
  import cfh_pkg::*;

  localparam int unsigned TB_SLOTS  = SLOTS_DEFAULT;
  localparam int unsigned N_RANDOM  = 500;     // result-bearing items in the random part
  localparam int unsigned DRAIN     = 64;      // settle time after the last expected result
  localparam int unsigned CYCLE_CAP = 200000;  // hang guard on the whole run
  localparam int unsigned POOL_MAX  = 24;

  // one expected result, field for field as the block reports it
  typedef struct packed {
    status_e                status;
    logic [MOTOR_OUT_W-1:0] found;
    logic [CNT_W-1:0]       conflicts;
    logic [CNT_W-1:0]       fulls;
    logic [BUS_W-1:0]       c_bus;
    logic [ID_W-1:0]        c_id;
    logic [MOTOR_OUT_W-1:0] kept;
    logic [MOTOR_OUT_W-1:0] dropped;
  } table_resp_t;

  // directed stimulus row; typed rows carry a hand-written status and found motor
  typedef struct packed {
    cmd_e                   cmd;
    logic [BUS_W-1:0]       bus;
    logic [ID_W-1:0]        id;
    logic [MOTOR_W-1:0]     motor;
    bit                     typed;
    status_e                st;
    logic [MOTOR_OUT_W-1:0] found;
  } stim_row_t;

  // DUT-facing signals; the inputs are known from time zero
  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             command_i = CMD_CLEAR;
  logic [BUS_W-1:0]       bus_i = '0;
  logic [ID_W-1:0]        feedback_id_i = '0;
  logic [MOTOR_W-1:0]     motor_id_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [2:0]             status_o;
  logic [MOTOR_OUT_W-1:0] found_motor_o;
  logic [CNT_W-1:0]       conflict_total_o;
  logic [CNT_W-1:0]       full_total_o;
  logic [BUS_W-1:0]       conflict_bus_o;
  logic [ID_W-1:0]        conflict_id_o;
  logic [MOTOR_OUT_W-1:0] conflict_kept_o;
  logic [MOTOR_OUT_W-1:0] conflict_dropped_o;

  // predictor copy of the table and its diagnostics
  bit                     mdl_used  [TB_SLOTS];
  logic [BUS_W-1:0]       mdl_bus   [TB_SLOTS];
  logic [ID_W-1:0]        mdl_id    [TB_SLOTS];
  logic [MOTOR_OUT_W-1:0] mdl_motor [TB_SLOTS];
  logic [CNT_W-1:0]       mdl_conflicts;
  logic [CNT_W-1:0]       mdl_fulls;
  logic [BUS_W-1:0]       mdl_c_bus;
  logic [ID_W-1:0]        mdl_c_id;
  logic [MOTOR_OUT_W-1:0] mdl_kept;
  logic [MOTOR_OUT_W-1:0] mdl_dropped;

  table_resp_t      expected_q[$];  // results owed by the block, oldest first
  stim_row_t        script[$];
  int unsigned      err_count = 0;
  int unsigned      cycle_count = 0;
  bit               calm = 1'b0;    // both sides stop idling while set

  // key pool for the random part: a handful of keys, often sharing home slots
  logic [BUS_W-1:0]   pool_bus   [POOL_MAX];
  logic [ID_W-1:0]    pool_id    [POOL_MAX];
  logic [MOTOR_W-1:0] pool_motor [POOL_MAX];
  int unsigned        pool_n = 1;

  can_feedback_id_hash_table u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .bus_i              (bus_i),
    .feedback_id_i      (feedback_id_i),
    .motor_id_i         (motor_id_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .found_motor_o      (found_motor_o),
    .conflict_total_o   (conflict_total_o),
    .full_total_o       (full_total_o),
    .conflict_bus_o     (conflict_bus_o),
    .conflict_id_o      (conflict_id_o),
    .conflict_kept_o    (conflict_kept_o),
    .conflict_dropped_o (conflict_dropped_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop if the run hangs
  initial begin
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // empty table, counters zero, kept/dropped read "none"
  function automatic void clear_table();
    for (int i = 0; i < TB_SLOTS; i++) begin
      mdl_used[i]  = 1'b0;
      mdl_bus[i]   = '0;
      mdl_id[i]    = '0;
      mdl_motor[i] = '0;
    end
    mdl_conflicts = '0;
    mdl_fulls     = '0;
    mdl_c_bus     = '0;
    mdl_c_id      = '0;
    mdl_kept      = MOTOR_NONE;
    mdl_dropped   = MOTOR_NONE;
  endfunction

  // Applies one command to the predictor table. Returns 0 for the unused
  // command code, which yields no result.
  function automatic bit predict_response(input cmd_e cmd, input logic [BUS_W-1:0] bus,
                                          input logic [ID_W-1:0] id,
                                          input logic [MOTOR_W-1:0] motor,
                                          output table_resp_t r);
    int unsigned home;
    int unsigned s;
    bit          done;
    r.status = ST_MISS;
    r.found  = MOTOR_NONE;
    done     = 1'b0;
    // bus << 5 never touches the low bits, so home is really id mod SLOTS
    home = ((int'(id) ^ (int'(bus) << BUS_SHIFT)) & 32'hFFFF) % TB_SLOTS;
    case (cmd)
      CMD_CLEAR: begin
        clear_table();
        r.status = ST_CLEARED;
      end
      CMD_INSERT: begin
        if (bus == '0 || motor >= MOTORS) begin
          r.status = ST_REJECTED;
        end else begin
          for (int i = 0; i < TB_SLOTS; i++) begin
            s = (home + i) % TB_SLOTS;
            if (!done && !mdl_used[s]) begin
              mdl_used[s]  = 1'b1;
              mdl_bus[s]   = bus;
              mdl_id[s]    = id;
              mdl_motor[s] = {1'b0, motor};
              r.status     = ST_INSERTED;
              done         = 1'b1;
            end else if (!done && mdl_bus[s] == bus && mdl_id[s] == id) begin
              // same key met first: keep the old entry
              if (mdl_motor[s] == {1'b0, motor}) begin
                r.status = ST_SAME;
              end else begin
                mdl_conflicts = mdl_conflicts + 1'b1;
                mdl_c_bus     = bus;
                mdl_c_id      = id;
                mdl_kept      = mdl_motor[s];
                mdl_dropped   = {1'b0, motor};
                r.status      = ST_CONFLICT;
              end
              done = 1'b1;
            end
          end
          if (!done) begin
            mdl_fulls = mdl_fulls + 1'b1;
            r.status  = ST_FULL;
          end
        end
      end
      CMD_LOOKUP: begin
        // stops at the first empty slot or at the key; bus 0 simply misses
        for (int i = 0; i < TB_SLOTS; i++) begin
          s = (home + i) % TB_SLOTS;
          if (!done && !mdl_used[s]) begin
            done = 1'b1;
          end else if (!done && mdl_bus[s] == bus && mdl_id[s] == id) begin
            r.status = ST_HIT;
            r.found  = mdl_motor[s];
            done     = 1'b1;
          end
        end
      end
      default: return 1'b0;
    endcase
    r.conflicts = mdl_conflicts;
    r.fulls     = mdl_fulls;
    r.c_bus     = mdl_c_bus;
    r.c_id      = mdl_c_id;
    r.kept      = mdl_kept;
    r.dropped   = mdl_dropped;
    return 1'b1;
  endfunction

  function automatic stim_row_t mk_row(input cmd_e cmd, input logic [BUS_W-1:0] bus,
                                       input logic [ID_W-1:0] id,
                                       input logic [MOTOR_W-1:0] motor, input bit typed,
                                       input status_e st, input logic [MOTOR_OUT_W-1:0] found);
    stim_row_t row_v;
    row_v.cmd   = cmd;
    row_v.bus   = bus;
    row_v.id    = id;
    row_v.motor = motor;
    row_v.typed = typed;
    row_v.st    = st;
    row_v.found = found;
    return row_v;
  endfunction

  // fresh key pool; half the pools crowd into four neighboring home slots
  function automatic void new_pool();
    logic [3:0] base;
    bit         crowd;
    base   = 4'($urandom_range(0, 15));
    crowd  = 1'($urandom_range(0, 1));
    pool_n = $urandom_range(3, POOL_MAX);
    for (int k = 0; k < pool_n; k++) begin
      pool_bus[k]   = ($urandom_range(0, 19) == 0) ? '0 : BUS_W'($urandom_range(1, 255));
      pool_id[k]    = crowd ? {7'($urandom_range(0, 127)), 4'(base + $urandom_range(0, 3))}
                            : ID_W'($urandom_range(0, 2047));
      pool_motor[k] = MOTOR_W'($urandom_range(0, 7));
    end
  endfunction

  // One item on the request side: optional idle gap, hold until taken, then
  // book the expected result. Valid stays high across back-to-back items.
  task automatic issue_request(input stim_row_t sr);
    int unsigned gap;
    table_resp_t r;
    bit          has;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= sr.cmd;
    bus_i         <= sr.bus;
    feedback_id_i <= sr.id;
    motor_id_i    <= sr.motor;
    do @(posedge clk_i); while (in_stall_o);
    has = predict_response(sr.cmd, sr.bus, sr.id, sr.motor, r);
    if (has) begin
      if (sr.typed) begin
        r.status = sr.st;
        r.found  = sr.found;
      end
      expected_q.push_back(r);
    end
  endtask

  function automatic void cmp_field(input string name, input logic [CNT_W-1:0] exp_v,
                                    input logic [CNT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Result side: random stall after each taken result, check on every take.
  initial begin
    int unsigned hold;
    table_resp_t e;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, status got %0d", $time, status_o);
          err_count++;
        end else begin
          e = expected_q.pop_front();
          cmp_field("status",           CNT_W'(e.status),  CNT_W'(status_o));
          cmp_field("found_motor",      CNT_W'(e.found),   CNT_W'(found_motor_o));
          cmp_field("conflict_total",   e.conflicts,       conflict_total_o);
          cmp_field("full_total",       e.fulls,           full_total_o);
          cmp_field("conflict_bus",     CNT_W'(e.c_bus),   CNT_W'(conflict_bus_o));
          cmp_field("conflict_id",      CNT_W'(e.c_id),    CNT_W'(conflict_id_o));
          cmp_field("conflict_kept",    CNT_W'(e.kept),    CNT_W'(conflict_kept_o));
          cmp_field("conflict_dropped", CNT_W'(e.dropped), CNT_W'(conflict_dropped_o));
        end
        hold = calm ? 0 : $urandom_range(0, 6);
      end
      out_stall_i <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned n_keyed;
    int unsigned n_sent;
    int unsigned pick;
    int unsigned k;
    stim_row_t   sr;

    clear_table();
    new_pool();

    // After reset: lookup misses, bus 0 insert rejected.
    script.push_back(mk_row(CMD_LOOKUP, 8'd5, 11'd100, 3'd0, 1, ST_MISS, MOTOR_NONE));
    script.push_back(mk_row(CMD_INSERT, 8'd0, 11'd5, 3'd3, 1, ST_REJECTED, MOTOR_NONE));
    // Top-of-range key and motor: insert, hit, same again, then a conflict.
    script.push_back(mk_row(CMD_INSERT, 8'd255, 11'd2047, 3'd7, 1, ST_INSERTED, MOTOR_NONE));
    script.push_back(mk_row(CMD_LOOKUP, 8'd255, 11'd2047, 3'd0, 1, ST_HIT, 4'd7));
    script.push_back(mk_row(CMD_INSERT, 8'd255, 11'd2047, 3'd7, 1, ST_SAME, MOTOR_NONE));
    script.push_back(mk_row(CMD_INSERT, 8'd255, 11'd2047, 3'd0, 1, ST_CONFLICT, MOTOR_NONE));
    // bus 0 lookup probes like any key and misses
    script.push_back(mk_row(CMD_LOOKUP, 8'd0, 11'd0, 3'd0, 1, ST_MISS, MOTOR_NONE));
    // unused command code: swallowed, no result
    script.push_back(mk_row(CMD_NONE, 8'd255, 11'd2047, 3'd5, 0, ST_MISS, MOTOR_NONE));
    script.push_back(mk_row(CMD_INSERT, 8'd1, 11'd0, 3'd0, 0, ST_MISS, MOTOR_NONE));
    script.push_back(mk_row(CMD_CLEAR, 8'd0, 11'd0, 3'd0, 1, ST_CLEARED, MOTOR_NONE));
    // Fill all slots from one home slot so probing wraps around the table.
    for (k = 0; k < TB_SLOTS; k++)
      script.push_back(mk_row(CMD_INSERT, BUS_W'(k + 1), ID_W'(16 * k + 3), MOTOR_W'(k),
                              0, ST_MISS, MOTOR_NONE));
    script.push_back(mk_row(CMD_INSERT, 8'd200, 11'd3, 3'd1, 1, ST_FULL, MOTOR_NONE));
    // full table: absent key probes every slot and misses; last key needs a full probe
    script.push_back(mk_row(CMD_LOOKUP, 8'd200, 11'd3, 3'd0, 1, ST_MISS, MOTOR_NONE));
    script.push_back(mk_row(CMD_LOOKUP, BUS_W'(TB_SLOTS), ID_W'(16 * (TB_SLOTS - 1) + 3),
                            3'd0, 0, ST_MISS, MOTOR_NONE));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) issue_request(script[i]);

    // Random part: mostly inserts and lookups on the current key pool with
    // the pool's motor, plus conflicts, clears, stray keys and code 3.
    n_keyed = 0;
    n_sent  = 0;
    while (n_keyed < N_RANDOM) begin
      if (n_sent % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, pool_n - 1);
      sr   = mk_row(CMD_LOOKUP, pool_bus[k], pool_id[k], pool_motor[k], 0, ST_MISS,
                    MOTOR_NONE);
      if (pick < 3) begin
        sr.cmd = CMD_CLEAR;
        if ($urandom_range(0, 1) == 1) new_pool();
      end else if (pick < 5) begin
        sr.cmd = CMD_NONE;
      end else if (pick < 8) begin
        sr.cmd   = cmd_e'($urandom_range(CMD_INSERT, CMD_LOOKUP));
        sr.bus   = BUS_W'($urandom_range(0, 255));
        sr.id    = ID_W'($urandom_range(0, 2047));
        sr.motor = MOTOR_W'($urandom_range(0, 7));
      end else if (pick < 10) begin
        new_pool();  // switch keys without a clear, so the table fills up
      end else if (pick < 57) begin
        sr.cmd = CMD_INSERT;
        if ($urandom_range(0, 4) == 0) sr.motor = MOTOR_W'($urandom_range(0, 7));
      end
      if (pick < 3 || pick >= 5) begin
        if (pick < 8 || pick >= 10) begin
          issue_request(sr);
          n_keyed++;
          n_sent++;
        end
      end else begin
        issue_request(sr);
        n_sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cfh_pkg.sv
design/cfh_ram.sv
design/cfh_front.sv
design/cfh_queue.sv
design/cfh_back.sv
design/can_feedback_id_hash_table.sv
sim/tb_can_feedback_id_hash_table.sv
